[rtl/wais_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wais_pkg
// shared types and constants for the weapon arm interlock with pulse slew
// ----------------------------------------------------------------------------
package wais_pkg;

	localparam int THR_W   = 16;
	localparam int PULSE_W = 12;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int REG_W   = 3;

	// register indexes, byte address is 4 * index
	localparam logic [REG_W-1:0] REG_ARM_THR   = 3'd0;
	localparam logic [REG_W-1:0] REG_REARM_THR = 3'd1;
	localparam logic [REG_W-1:0] REG_PULSE_MIN = 3'd2;
	localparam logic [REG_W-1:0] REG_PULSE_MAX = 3'd3;
	localparam logic [REG_W-1:0] REG_SLEW_STEP = 3'd4;

	// reset values
	localparam logic signed [THR_W-1:0] ARM_THR_RST   = 16'sd820;
	localparam logic signed [THR_W-1:0] REARM_THR_RST = 16'sd328;
	localparam logic [PULSE_W-1:0]      PULSE_MIN_RST = 12'd1000;
	localparam logic [PULSE_W-1:0]      PULSE_MAX_RST = 12'd2000;
	localparam logic [PULSE_W-1:0]      SLEW_STEP_RST = 12'd10;
	localparam logic [PULSE_W-1:0]      PREV_PULSE_RST = 12'd1000;

	typedef struct packed {
		logic                    arm_req;
		logic                    kill_req;
		logic                    link_ok;
		logic                    system_error;
		logic signed [THR_W-1:0] throttle;
	} in_item_t;

	typedef struct packed {
		logic [PULSE_W-1:0] pulse_us;
		logic               armed;
	} out_item_t;

endpackage

[rtl/weapon_arm_interlock_slew.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weapon_arm_interlock_slew
// arming interlock with throttle to esc pulse scaling and slew limiting
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_ready / in_item) takes one update tick per item:
//   switches, link health, error flag and a signed throttle
//   out channel (out_valid / out_ready / out_item) returns one item per input
//   item, in order: the slew-limited pulse width and the armed flag
//   apb port sets thresholds, pulse range and slew step; write it only while
//   no item is in flight
// timing
//   three register stages: input register, arm decision and scaled target
//   (one multiply), then the slew step into the output register
//   out_valid rises once the item has passed the stage 2 and output registers;
//   one item per cycle sustained while out_ready stays high, since each state
//   loop (arm flag, held throttle, last pulse) closes within a single stage
// reset
//   arst_n clears the pipeline, disarms, clears the held throttle, puts the
//   last pulse at 1000 us and loads the register defaults
// stalls
//   each stage moves when the one after it is empty or moving, so the
//   pipeline keeps filling while a finished item waits at the output
// ----------------------------------------------------------------------------
module weapon_arm_interlock_slew #(
	parameter int THROTTLE_FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// item input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  wais_pkg::in_item_t                 in_item,
	// item output
	output logic                               out_valid,
	input  logic                               out_ready,
	output wais_pkg::out_item_t                out_item,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [wais_pkg::ADDR_W-1:0]        paddr,
	input  logic [wais_pkg::DATA_W-1:0]        pwdata,
	output logic [wais_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	localparam int THR_W   = wais_pkg::THR_W;
	localparam int PULSE_W = wais_pkg::PULSE_W;
	localparam int T_W     = THROTTLE_FRAC_BITS + 1;
	localparam int PROD_W  = T_W + PULSE_W;
	localparam logic signed [THR_W-1:0] THR_ONE = THR_W'(1 << THROTTLE_FRAC_BITS);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic signed [THR_W-1:0] arm_thr_q;
	logic signed [THR_W-1:0] rearm_thr_q;
	logic [PULSE_W-1:0]      pulse_min_q;
	logic [PULSE_W-1:0]      pulse_max_q;
	logic [PULSE_W-1:0]      slew_step_q;
	logic                    cfg_wr;
	logic [wais_pkg::REG_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[wais_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_thr_q   <= wais_pkg::ARM_THR_RST;
			rearm_thr_q <= wais_pkg::REARM_THR_RST;
			pulse_min_q <= wais_pkg::PULSE_MIN_RST;
			pulse_max_q <= wais_pkg::PULSE_MAX_RST;
			slew_step_q <= wais_pkg::SLEW_STEP_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				wais_pkg::REG_ARM_THR:   arm_thr_q   <= pwdata[THR_W-1:0];
				wais_pkg::REG_REARM_THR: rearm_thr_q <= pwdata[THR_W-1:0];
				wais_pkg::REG_PULSE_MIN: pulse_min_q <= pwdata[PULSE_W-1:0];
				wais_pkg::REG_PULSE_MAX: pulse_max_q <= pwdata[PULSE_W-1:0];
				wais_pkg::REG_SLEW_STEP: slew_step_q <= pwdata[PULSE_W-1:0];
				default: ; // unmapped addresses are ignored
			endcase
		end
	end

	// read back, thresholds sign extended
	always_comb begin
		unique case (cfg_idx)
			wais_pkg::REG_ARM_THR:
				prdata = {{(wais_pkg::DATA_W-THR_W){arm_thr_q[THR_W-1]}}, arm_thr_q};
			wais_pkg::REG_REARM_THR:
				prdata = {{(wais_pkg::DATA_W-THR_W){rearm_thr_q[THR_W-1]}}, rearm_thr_q};
			wais_pkg::REG_PULSE_MIN:
				prdata = {{(wais_pkg::DATA_W-PULSE_W){1'b0}}, pulse_min_q};
			wais_pkg::REG_PULSE_MAX:
				prdata = {{(wais_pkg::DATA_W-PULSE_W){1'b0}}, pulse_max_q};
			wais_pkg::REG_SLEW_STEP:
				prdata = {{(wais_pkg::DATA_W-PULSE_W){1'b0}}, slew_step_q};
			default:
				prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// pipeline flow control: a stage loads when it is empty or draining
	// ------------------------------------------------------------------
	logic v_s1, v_s2, out_v_q;
	logic adv_s1, adv_s2, adv_out;

	assign adv_out  = !out_v_q || out_ready;
	assign adv_s2   = !v_s2 || adv_out;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// ------------------------------------------------------------------
	// stage 1: input register
	// ------------------------------------------------------------------
	wais_pkg::in_item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: interlock decision and scaled target
	// ------------------------------------------------------------------
	logic                    arm_q;
	logic signed [THR_W-1:0] held_q;
	logic                    arm_nxt;
	logic signed [THR_W-1:0] held_nxt;
	logic                    unsafe;
	logic [T_W-1:0]          t_clamp;
	logic [PULSE_W-1:0]      range;
	logic [PROD_W-1:0]       prod;
	logic [PULSE_W-1:0]      target;
	logic [PULSE_W-1:0]      target_s2;
	logic                    armed_s2;
	logic                    ld_s2;

	assign ld_s2  = v_s1 && adv_s2;
	assign unsafe = !item_s1.arm_req || item_s1.kill_req ||
			!item_s1.link_ok || item_s1.system_error;

	always_comb begin
		arm_nxt  = arm_q;
		held_nxt = held_q;
		if (unsafe) begin
			// any unsafe input drops the arm and records the throttle
			arm_nxt  = 1'b0;
			held_nxt = item_s1.throttle;
		end else if (!arm_q) begin
			// hysteresis: disarmed above the arm ceiling needs the stricter
			// re-arm ceiling before arming again
			if (held_q > arm_thr_q) begin
				if (item_s1.throttle < rearm_thr_q) begin
					arm_nxt  = 1'b1;
					held_nxt = item_s1.throttle;
				end
			end else if (item_s1.throttle <= arm_thr_q) begin
				arm_nxt  = 1'b1;
				held_nxt = item_s1.throttle;
			end
		end
	end

	// clamp throttle to [0, 1.0]
	always_comb begin
		priority if (item_s1.throttle < 0) begin
			t_clamp = '0;
		end else if (item_s1.throttle > THR_ONE) begin
			t_clamp = THR_ONE[T_W-1:0];
		end else begin
			t_clamp = item_s1.throttle[T_W-1:0];
		end
	end

	// disarmed or inverted range collapses the target to the minimum
	assign range  = (arm_nxt && (pulse_max_q >= pulse_min_q)) ?
			(pulse_max_q - pulse_min_q) : '0;
	assign prod   = PROD_W'(t_clamp) * PROD_W'(range);
	assign target = pulse_min_q + prod[THROTTLE_FRAC_BITS +: PULSE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2   <= 1'b0;
			arm_q  <= 1'b0;
			held_q <= '0;
		end else begin
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (ld_s2) begin
				arm_q  <= arm_nxt;
				held_q <= held_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			target_s2 <= target;
			armed_s2  <= arm_nxt;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: slew limit into the output register
	// ------------------------------------------------------------------
	logic [PULSE_W-1:0]      prev_q;
	logic [PULSE_W-1:0]      pulse_nxt;
	logic signed [PULSE_W:0] delta;
	logic signed [PULSE_W:0] step;
	logic                    ld_out;
	wais_pkg::out_item_t     out_q;

	assign ld_out = v_s2 && adv_out;
	assign delta  = $signed({1'b0, target_s2}) - $signed({1'b0, prev_q});
	assign step   = $signed({1'b0, slew_step_q});

	always_comb begin
		priority if (delta > step) begin
			pulse_nxt = prev_q + slew_step_q;
		end else if (delta < -step) begin
			pulse_nxt = prev_q - slew_step_q;
		end else begin
			pulse_nxt = target_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			prev_q  <= wais_pkg::PREV_PULSE_RST;
		end else begin
			if (adv_out) begin
				out_v_q <= v_s2;
			end
			if (ld_out) begin
				prev_q <= pulse_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q.pulse_us <= pulse_nxt;
			out_q.armed    <= armed_s2;
		end
	end

	assign out_valid = out_v_q;
	assign out_item  = out_q;

endmodule

[rtl/wais_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wais_checker
// port-level checks for the weapon arm interlock, bound to the top level
// ----------------------------------------------------------------------------
module wais_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  wais_pkg::out_item_t         out_item,
	input  logic                        pready
);

	// an empty output stage means the whole pipeline can move
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused while output stage is empty");

	// a draining output lets every stage advance
	a_drain_takes: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input refused while output is draining");

	// a stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled output item changed or dropped");

	// configuration port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid || !in_valid |-> pready)
		else $error("pready dropped");

endmodule

bind weapon_arm_interlock_slew wais_checker u_wais_checker (.*);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the weapon arm interlock with esc pulse slew
// ----------------------------------------------------------------------------
// a directed run at the reset settings walks the arm, disarm and hysteresis
// paths, then phases of random ticks run under fixed extreme settings and
// random settings written over apb between phases. a scoreboard class mirrors
// the arm flag, the held throttle and the last pulse, predicts one pulse and
// armed flag per accepted tick and checks each output item in order. both
// handshake sides idle at random, the receiver holds off for a long stretch
// twice so that the pipeline backs up, and the sender pauses once to drain
// ----------------------------------------------------------------------------
module tb_top;
	import wais_pkg::*;

	localparam int FRAC        = 14;
	localparam int DRAIN_WAIT  = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT    = 8;
	localparam int NUM_PHASES  = 8;

	// index past the last register, writes there must change nothing
	localparam logic [REG_W-1:0] REG_UNUSED = 3'd5;

	// predicted state of the block and a queue of ticks still to come out
	class pulse_scoreboard;
		logic signed [THR_W-1:0] arm_thr;
		logic signed [THR_W-1:0] rearm_thr;
		logic [PULSE_W-1:0]      pmin;
		logic [PULSE_W-1:0]      pmax;
		logic [PULSE_W-1:0]      step;
		bit                      armed_q;
		logic signed [THR_W-1:0] held_thr;
		logic [PULSE_W-1:0]      last_pulse;
		out_item_t               expected_pulses[$];
		int unsigned             errors;

		function new();
			arm_thr    = ARM_THR_RST;
			rearm_thr  = REARM_THR_RST;
			pmin       = PULSE_MIN_RST;
			pmax       = PULSE_MAX_RST;
			step       = SLEW_STEP_RST;
			armed_q    = 1'b0;
			held_thr   = '0;
			last_pulse = PREV_PULSE_RST;
			errors     = 0;
		endfunction

		function void set_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_ARM_THR:   arm_thr   = val[THR_W-1:0];
				REG_REARM_THR: rearm_thr = val[THR_W-1:0];
				REG_PULSE_MIN: pmin      = val[PULSE_W-1:0];
				REG_PULSE_MAX: pmax      = val[PULSE_W-1:0];
				REG_SLEW_STEP: step      = val[PULSE_W-1:0];
				default: ;
			endcase
		endfunction

		function out_item_t predict_tick(in_item_t it);
			logic signed [THR_W-1:0] thr;
			bit   go;
			int   t;
			int   tgt;
			int   delta;
			out_item_t res;
			thr = it.throttle;
			go  = 1'b0;
			if (!it.arm_req || it.kill_req || !it.link_ok || it.system_error) begin
				armed_q  = 1'b0;
				held_thr = thr;
			end else if (!armed_q) begin
				// after a disarm at high throttle the stricter re-arm ceiling applies
				if (held_thr > arm_thr) begin
					if (thr < rearm_thr)
						go = 1'b1;
				end else if (thr <= arm_thr) begin
					go = 1'b1;
				end
				if (go) begin
					armed_q  = 1'b1;
					held_thr = thr;
				end
			end
			// max below min keeps the target at min
			tgt = int'(pmin);
			if (armed_q && pmax >= pmin) begin
				t = int'(thr);
				if (t < 0)
					t = 0;
				if (t > (1 << FRAC))
					t = 1 << FRAC;
				tgt = int'(pmin) + ((t * (int'(pmax) - int'(pmin))) >>> FRAC);
			end
			delta = tgt - int'(last_pulse);
			if (delta > int'(step))
				last_pulse = last_pulse + step;
			else if (delta < -int'(step))
				last_pulse = last_pulse - step;
			else
				last_pulse = PULSE_W'(tgt);
			res.pulse_us = last_pulse;
			res.armed    = armed_q;
			return res;
		endfunction

		function void note_input(in_item_t it);
			expected_pulses.push_back(predict_tick(it));
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_item;
			if (expected_pulses.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output item: pulse %0d armed %0b",
						got.pulse_us, got.armed);
				return;
			end
			exp_item = expected_pulses.pop_front();
			if (got.pulse_us !== exp_item.pulse_us || got.armed !== exp_item.armed) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected pulse %0d armed %0b, got pulse %0d armed %0b",
						exp_item.pulse_us, exp_item.armed, got.pulse_us, got.armed);
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_ready;
	out_item_t           out_item;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	pulse_scoreboard sb;

	// calm turns off random idling on both sides
	bit calm;
	// receiver hold-off request, picked up by the receiver process
	int hold_req;

	weapon_arm_interlock_slew #(
		.THROTTLE_FRAC_BITS(FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// output side: random stalls plus long hold-offs counted here
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!calm && $urandom_range(99) < IDLE_PCT) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// every accepted output item goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	// hard stop, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("[weapon_arm_interlock_slew] ERROR");
		$finish;
	end

	function automatic in_item_t mk(int a, int k, int l, int e, logic signed [THR_W-1:0] t);
		in_item_t it;
		it.arm_req      = 1'(a);
		it.kill_req     = 1'(k);
		it.link_ok      = 1'(l);
		it.system_error = 1'(e);
		it.throttle     = t;
		return it;
	endfunction

	// mostly safe ticks, throttle aimed at the thresholds and the scaling range
	function automatic in_item_t rand_item();
		in_item_t it;
		int pick;
		logic signed [THR_W-1:0] t;
		if ($urandom_range(99) < 85) begin
			it = mk(1, 0, 1, 0, '0);
		end else begin
			it = mk($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1), '0);
		end
		pick = $urandom_range(99);
		if (pick < 20)
			t = THR_W'($urandom);
		else if (pick < 40)
			t = THR_W'(int'(sb.arm_thr) + int'($urandom_range(0, 16)) - 8);
		else if (pick < 55)
			t = THR_W'(int'(sb.rearm_thr) + int'($urandom_range(0, 16)) - 8);
		else if (pick < 90)
			t = THR_W'($urandom_range(0, 1 << FRAC));
		else begin
			case ($urandom_range(0, 6))
				0: t = 16'sh8000;
				1: t = 16'sh7fff;
				2: t = '0;
				3: t = THR_W'(1 << FRAC);
				4: t = THR_W'((1 << FRAC) - 1);
				5: t = THR_W'((1 << FRAC) + 1);
				default: t = -16'sd1;
			endcase
		end
		it.throttle = t;
		return it;
	endfunction

	// offer one item, idling first now and then, and note it once taken
	task automatic send_item(in_item_t it);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(it);
	endtask

	// stop offering and wait until every predicted item has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_pulses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// setup cycle, access cycle, then the bus goes quiet
	task automatic apb_write(logic [REG_W-1:0] idx, logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic write_all(int a, int r, int mn, int mx, int st);
		apb_write(REG_ARM_THR, DATA_W'(a));
		apb_write(REG_REARM_THR, DATA_W'(r));
		apb_write(REG_PULSE_MIN, DATA_W'(mn));
		apb_write(REG_PULSE_MAX, DATA_W'(mx));
		apb_write(REG_SLEW_STEP, DATA_W'(st));
	endtask

	initial begin : stimulus
		in_item_t dir_items[$];
		int a;
		int r;
		int mn;
		int mx;
		int st;
		int n;
		sb       = new();
		calm     = 1'b0;
		hold_req = 0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed run at reset settings: arm 820, re-arm 328, pulse 1000..2000
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd0));      // arms at zero throttle
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd16384));  // full throttle, slews up
		dir_items.push_back(mk(1, 0, 1, 0, 16'sh7fff));   // clamps above full
		dir_items.push_back(mk(1, 0, 1, 0, 16'sh8000));   // clamps below zero
		dir_items.push_back(mk(1, 1, 1, 0, 16'sd16384));  // kill at high throttle
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd500));    // under arm, over re-arm: stays off
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd328));    // re-arm needs strictly below
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd327));    // re-arms
		dir_items.push_back(mk(1, 0, 0, 0, 16'sd820));    // link lost at the arm ceiling
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd820));    // held equals ceiling, plain rule
		dir_items.push_back(mk(1, 0, 1, 1, 16'sd821));    // error just above ceiling
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd821));    // hysteresis blocks
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd0));      // re-arms
		dir_items.push_back(mk(0, 0, 1, 0, 16'sd0));      // arm request off
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd821));    // above ceiling, no arming
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd16384));
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd100));    // arms
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd16383));
		dir_items.push_back(mk(1, 0, 1, 0, 16'sd1));
		dir_items.push_back(mk(0, 1, 0, 1, 16'sh7fff));   // every unsafe flag at once
		dir_items.push_back(mk(1, 0, 1, 0, -16'sd1));
		foreach (dir_items[i])
			send_item(dir_items[i]);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				// widest range and largest step
				0: begin a = 16384; r = -32768; mn = 0; mx = 4095; st = 4095; end
				// max below min with a zero slew step
				1: begin a = 820; r = 328; mn = 3000; mx = 500; st = 0; end
				// arm ceiling at the most negative throttle, re-arm ceiling at the top, step of one
				2: begin a = -32768; r = 32767; mn = 1000; mx = 2000; st = 1; end
				// arms on every safe tick, pulse pinned at the top
				3: begin a = 32767; r = -32768; mn = 4095; mx = 4095; st = 4095; end
				default: begin
					a  = ($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
						: int'($urandom_range(0, 2000));
					r  = ($urandom_range(0, 3) == 0) ? int'($signed(16'($urandom)))
						: int'($urandom_range(0, 2000));
					if ($urandom_range(99) < 70) begin
						mn = $urandom_range(800, 1200);
						mx = $urandom_range(1800, 2200);
					end else begin
						mn = $urandom_range(0, 4095);
						mx = $urandom_range(0, 4095);
					end
					if ($urandom_range(99) < 70)
						st = $urandom_range(1, 64);
					else if ($urandom_range(99) < 30)
						st = 0;
					else
						st = $urandom_range(0, 4095);
				end
			endcase
			write_all(a, r, mn, mx, st);
			// a write past the last register must not disturb anything
			if (ph == 2)
				apb_write(REG_UNUSED, 32'hffff_ffff);
			calm = (ph == 4);
			n    = (ph == 1) ? 60 : 190;
			for (int i = 0; i < n; i++) begin
				// long output hold-off while ticks keep coming
				if ((ph == 3 || ph == 6) && i == 80)
					hold_req = HOLD_CYCLES;
				// sender pause until the pipeline is empty
				if (ph == 5 && i == 90)
					wait_idle();
				send_item(rand_item());
			end
		end

		wait_idle();
		if (sb.errors == 0 && sb.expected_pulses.size() == 0)
			$display("[weapon_arm_interlock_slew] OK");
		else
			$display("[weapon_arm_interlock_slew] ERROR");
		$finish;
	end

endmodule
